// ===== hw/rtl/lppd_pkg.sv =====
// lppd_pkg: shared types and codes for the length-prefixed packet deframer
// no dependencies; imported by length_prefixed_packet_deframer
`default_nettype none

package lppd_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 32;
    localparam int KIND_W = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [1:0]        phase_t;

    localparam len_t MAX_LEN_RESET = 32'h1000_0000;

    // phase codes
    localparam phase_t PH_HEADER  = 2'd0;
    localparam phase_t PH_TYPE    = 2'd1;
    localparam phase_t PH_PAYLOAD = 2'd2;
    localparam phase_t PH_ERROR   = 2'd3;

    // byte classification on the result channel
    localparam kind_t KIND_HEADER  = 2'd0;
    localparam kind_t KIND_TYPE    = 2'd1;
    localparam kind_t KIND_PAYLOAD = 2'd2;
    localparam kind_t KIND_DROPPED = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/length_prefixed_packet_deframer.sv =====
// length_prefixed_packet_deframer: splits a byte stream into length-prefixed packets
// depends on lppd_pkg (types, phase and byte-kind codes)
//
//  channel | ports                                   | direction | role
//  --------+-----------------------------------------+-----------+---------------------------
//  s_      | s_valid s_ready s_data_byte             | in        | raw stream, one word a byte
//  m_      | m_valid m_ready m_byte_kind m_byte_out  | out       | one classified word a byte
//          | m_packet_kind m_end_of_packet           |           |
//          | m_length_error                          |           |
//  cfg_    | cfg_valid cfg_ready cfg_data            | in        | max_packet_length write
//
// one word a cycle sustained while m_ready stays high; a word is held in the input register,
// then in the result register, which drives m_valid, before it can leave
// the per-word header/length state update is 32-bit compares or a 32-bit decrement
// a stall on m_ready holds the result register and then the input register;
// s_ready drops only when both are full and the result is not being taken
// synchronous active-low reset returns to header phase (out of error); err_reg is not reset
`default_nettype none

module length_prefixed_packet_deframer
    import lppd_pkg::*;
#(
    parameter int LENGTH_BYTES = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [BYTE_W-1:0] s_data_byte,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [KIND_W-1:0]      m_byte_kind,
    output logic [BYTE_W-1:0]      m_byte_out,
    output logic [BYTE_W-1:0]      m_packet_kind,
    output logic                   m_end_of_packet,
    output logic                   m_length_error,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [LEN_W-1:0]  cfg_data
);

    localparam int ACC_W = BYTE_W * LENGTH_BYTES;
    localparam int CNT_W = $clog2(LENGTH_BYTES + 1);
    localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(LENGTH_BYTES);

    // configuration
    len_t max_len_reg;

    // input register
    logic  in_valid_reg;
    byte_t in_byte_reg;

    // deframer state
    phase_t           phase_reg,     phase_next;
    logic [CNT_W-1:0] hdr_cnt_reg,   hdr_cnt_next;
    logic [ACC_W-1:0] acc_reg,       acc_next;
    len_t             remain_reg,    remain_next;
    byte_t            cur_type_reg,  cur_type_next;

    // result register
    logic  out_valid_reg;
    kind_t kind_reg,  kind_next;
    byte_t byte_reg;
    byte_t pkind_reg, pkind_next;
    logic  eop_reg,   eop_next;
    logic  err_reg,   err_next;

    logic             advance;
    logic [CNT_W-1:0] cnt_inc;
    len_t             full_len;
    len_t             remain_dec;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign cnt_inc    = hdr_cnt_reg + 1'b1;
    assign remain_dec = remain_reg - 1'b1;

    always_comb begin
        acc_next = ACC_W'({acc_reg, in_byte_reg});
        full_len = LEN_W'(acc_next);
    end

    always_comb begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        remain_next   = remain_reg;
        cur_type_next = cur_type_reg;
        kind_next     = KIND_DROPPED;
        pkind_next    = '0;
        eop_next      = 1'b0;
        unique case (phase_reg)
            PH_HEADER: begin
                kind_next    = KIND_HEADER;
                hdr_cnt_next = cnt_inc;
                if (cnt_inc == HDR_LAST) begin
                    if (full_len == '0 || full_len > max_len_reg) begin
                        phase_next = PH_ERROR;
                    end else begin
                        remain_next = full_len;
                        phase_next  = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                kind_next     = KIND_TYPE;
                cur_type_next = in_byte_reg;
                pkind_next    = in_byte_reg;
                remain_next   = remain_dec;
                if (remain_dec == '0) begin
                    eop_next     = 1'b1;
                    phase_next   = PH_HEADER;
                    hdr_cnt_next = '0;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                kind_next   = KIND_PAYLOAD;
                pkind_next  = cur_type_reg;
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    eop_next     = 1'b1;
                    phase_next   = PH_HEADER;
                    hdr_cnt_next = '0;
                end
            end
            PH_ERROR: begin
                kind_next = KIND_DROPPED;
            end
            default: begin
                kind_next = KIND_DROPPED;
            end
        endcase
        // error is sticky: the error phase is never left
        err_next = (phase_next == PH_ERROR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hdr_cnt_reg  <= '0;
            acc_reg      <= '0;
            remain_reg   <= '0;
            cur_type_reg <= '0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            // accumulator restarts from zero with each new header
            acc_reg      <= (phase_next == PH_HEADER && hdr_cnt_next == '0) ? '0 : acc_next;
            remain_reg   <= remain_next;
            cur_type_reg <= cur_type_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg  <= kind_next;
            byte_reg  <= in_byte_reg;
            pkind_reg <= pkind_next;
            eop_reg   <= eop_next;
            err_reg   <= err_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_byte_kind     = kind_reg;
    assign m_byte_out      = byte_reg;
    assign m_packet_kind   = pkind_reg;
    assign m_end_of_packet = eop_reg;
    assign m_length_error  = err_reg;

endmodule

`default_nettype wire

// ===== test/length_prefixed_packet_deframer_tb.sv =====
// length_prefixed_packet_deframer_tb: self-checking bench for the packet deframer
// depends on lppd_pkg and length_prefixed_packet_deframer; predicts each classified
// word in step with the input stream and checks it as it leaves the result channel

module length_prefixed_packet_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lppd_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          HDR_BYTES   = 4;
    localparam int          RESET_CYC   = 6;
    localparam int          LONG_HOLD   = 300;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_CYC   = 10;
    localparam int          RAND_BYTES  = 400;
    localparam int          PHASE_BYTES = 75;
    localparam int unsigned LEN_CAP     = 40;

    typedef struct {
        kind_t kind;
        byte_t data;
        byte_t pkt_kind;
        logic  eop;
        logic  fault;
    } deframed_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    byte_t            s_data_byte = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    kind_t            m_byte_kind;
    byte_t            m_byte_out;
    byte_t            m_packet_kind;
    logic             m_end_of_packet;
    logic             m_length_error;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    len_t             cfg_data    = '0;

    // predictor state
    phase_t           frame_phase  = PH_HEADER;
    logic [2:0]       hdr_seen     = '0;
    len_t             len_gathered = '0;
    len_t             bytes_left   = '0;
    byte_t            pkt_type     = '0;
    logic             len_fault    = 1'b0;
    len_t             max_len      = MAX_LEN_RESET;

    byte_t            byte_queue[$];
    deframed_t        expected_words[$];
    int unsigned      mismatches    = 0;
    int unsigned      hold_requests = 0;
    int unsigned      hold_served   = 0;
    int unsigned      quiet_cycles  = 0;
    int unsigned      tx_gap        = 0;
    int unsigned      tx_burst      = 0;
    int unsigned      rx_stall      = 0;
    int unsigned      rx_burst      = 0;

    length_prefixed_packet_deframer #(
        .LENGTH_BYTES(HDR_BYTES)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_byte_kind     (m_byte_kind),
        .m_byte_out      (m_byte_out),
        .m_packet_kind   (m_packet_kind),
        .m_end_of_packet (m_end_of_packet),
        .m_length_error  (m_length_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int unsigned draw_gap(inout int unsigned burst_left);
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 4) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    task automatic deframe_byte(input byte_t b);
        deframed_t w;
        w.kind     = KIND_DROPPED;
        w.data     = b;
        w.pkt_kind = '0;
        w.eop      = 1'b0;
        case (frame_phase)
            PH_HEADER: begin
                w.kind       = KIND_HEADER;
                len_gathered = {len_gathered[LEN_W-BYTE_W-1:0], b};
                hdr_seen     = hdr_seen + 3'd1;
                if (hdr_seen >= HDR_BYTES) begin
                    if (len_gathered == '0 || len_gathered > max_len) begin
                        len_fault   = 1'b1;
                        frame_phase = PH_ERROR;
                    end else begin
                        bytes_left  = len_gathered;
                        frame_phase = PH_TYPE;
                    end
                end
            end
            PH_TYPE, PH_PAYLOAD: begin
                if (frame_phase == PH_TYPE) begin
                    w.kind   = KIND_TYPE;
                    pkt_type = b;
                end else begin
                    w.kind = KIND_PAYLOAD;
                end
                w.pkt_kind = pkt_type;
                bytes_left = bytes_left - 1;
                if (bytes_left == '0) begin
                    w.eop        = 1'b1;
                    frame_phase  = PH_HEADER;
                    hdr_seen     = '0;
                    len_gathered = '0;
                end else begin
                    frame_phase = PH_PAYLOAD;
                end
            end
            default: ;
        endcase
        w.fault = len_fault;
        expected_words.push_back(w);
    endtask

    // driver: one word offered at a time, held until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                deframe_byte(s_data_byte);
                tx_gap = draw_gap(tx_burst);
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    s_valid     <= 1'b1;
                    s_data_byte <= byte_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // monitor and result-side back-pressure
    always @(posedge aclk) begin
        deframed_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with no expectation: byte_out %0h", m_byte_out);
                    mismatches++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("byte_kind", w.kind, m_byte_kind);
                    check_field("byte_out", w.data, m_byte_out);
                    check_field("packet_kind", w.pkt_kind, m_packet_kind);
                    check_field("end_of_packet", w.eop, m_end_of_packet);
                    check_field("length_error", w.fault, m_length_error);
                end
            end
            if (hold_served < hold_requests) begin
                hold_served++;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                rx_stall = draw_gap(rx_burst);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL length_prefixed_packet_deframer");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_valid || expected_words.size() != 0)
            @(posedge aclk);
    endtask

    // only called with the block drained
    task automatic write_max_len(input len_t v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        max_len = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_header(input len_t plen);
        for (int i = HDR_BYTES - 1; i >= 0; i--)
            byte_queue.push_back(plen[8*i +: 8]);
    endtask

    task automatic queue_packet(input len_t plen, input byte_t ptype);
        queue_header(plen);
        byte_queue.push_back(ptype);
        for (len_t n = 1; n < plen; n++)
            byte_queue.push_back(byte_t'($urandom));
    endtask

    initial begin
        int unsigned random_bytes;
        int unsigned phase_bytes;
        int unsigned cap;
        int unsigned p;
        len_t        new_max;
        len_t        plen;

        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // type word closes a length-1 packet, then a short packet at the byte extremes
        queue_packet(1, 8'hFF);
        queue_header(3);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(8'h00);
        wait_idle();
        // length equal to the smallest maximum is still accepted
        write_max_len(1);
        queue_packet(1, 8'hA5);
        wait_idle();
        write_max_len('1);
        queue_packet(2, 8'h5A);
        wait_idle();

        random_bytes = 0;
        p = 0;
        while (random_bytes < RAND_BYTES) begin
            case (p % 5)
                0: new_max = '1;
                1: new_max = 1;
                2: new_max = MAX_LEN_RESET;
                3: new_max = len_t'($urandom) | 32'd64;
                default: new_max = $urandom_range(2, LEN_CAP);
            endcase
            write_max_len(new_max);
            cap = (max_len < LEN_CAP) ? max_len : LEN_CAP;
            // receiver holds off while the sender keeps offering, so the block backs up
            if (p == 2) hold_requests++;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                plen = ($urandom_range(9) == 0) ? cap : $urandom_range(1, cap);
                queue_packet(plen, byte_t'($urandom));
                phase_bytes += HDR_BYTES + plen;
            end
            random_bytes += phase_bytes;
            wait_idle();
            p++;
        end

        // one bad length to finish, as the error only clears on reset
        case ($urandom_range(2))
            0: queue_header('0);
            1: begin
                write_max_len($urandom_range(1, 32'hFFFF_FFFE));
                queue_header(max_len + 1);
            end
            default: begin
                write_max_len('0);
                queue_header(len_t'($urandom));
            end
        endcase
        repeat (20) byte_queue.push_back(byte_t'($urandom));

        wait_idle();
        repeat (DRAIN_CYC) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS length_prefixed_packet_deframer");
        else
            $display("FAIL length_prefixed_packet_deframer");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lppd_pkg.sv
hw/rtl/length_prefixed_packet_deframer.sv
test/length_prefixed_packet_deframer_tb.sv
